>>> rtl/mrbp_pkg.sv
// shared types, command codes and an enclosure helper function for the maxrects packer
// used by the controller, the datapath and the top level
package mrbp_pkg;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
  } rect_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_RESTART,
    CMD_RES_RST,
    CMD_LATCH,
    CMD_SCAN_EX,
    CMD_SPLIT_INIT,
    CMD_GROW_INIT,
    CMD_GROW_EX,
    CMD_GROW_END,
    CMD_RES_FAIL,
    CMD_SPLIT_EX,
    CMD_SPLIT_WR,
    CMD_CMP_INIT,
    CMD_CMP_EX,
    CMD_CMP_END,
    CMD_INC_I,
    CMD_INC_J,
    CMD_PR_ILOAD,
    CMD_RD_J,
    CMD_PR_JEX,
    CMD_RES_OK
  } cmd_t;

  typedef struct packed {
    logic i_lt_cnt;
    logic i_lt_n;
    logic j_lt_cnt;
    logic vi;
    logic vj;
    logic fit;
    logic grow_ok;
    logic wr_last;
  } stat_t;

  localparam logic [1:0] REG_ALLOW_GROWTH    = 2'd0;
  localparam logic [1:0] REG_ALLOW_ROTATIONS = 2'd1;
  localparam logic [1:0] REG_INIT_WIDTH      = 2'd2;
  localparam logic [1:0] REG_INIT_HEIGHT     = 2'd3;

  localparam logic [15:0] RESET_ATLAS_SIDE = 16'd512;

  // a encloses b, edges compared at 17 bits
  function automatic logic encloses(rect_t a, rect_t b);
    logic [16:0] ax1, ay1, bx1, by1;
    ax1 = {1'b0, a.x} + {1'b0, a.w};
    ay1 = {1'b0, a.y} + {1'b0, a.h};
    bx1 = {1'b0, b.x} + {1'b0, b.w};
    by1 = {1'b0, b.y} + {1'b0, b.h};
    return (a.x <= b.x) && (a.y <= b.y) && (ax1 >= bx1) && (ay1 >= by1);
  endfunction

endpackage

>>> rtl/max_rects_bssf_packer.sv
// maxrects best-short-side-fit packer, n free rectangles held in a single-port-read list:
// restart reloads the initial free rectangle; a place runs a scan, a split, a compact, a pairwise
// prune and a second compact, with an atlas doubling and rescan each time growth is needed;
// the memory read port and the prune pair loop bound the speed
// one item at a time: busy is high from acceptance until the result strobe
// synchronous active-low reset restores config defaults and runs a restart, with busy high during it
module max_rects_bssf_packer import mrbp_pkg::*; #(
  parameter int MAX_FREE_RECTS = 64,
  parameter int MAX_ATLAS_SIZE = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [15:0] in_rect_width,
  input  logic [15:0] in_rect_height,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  output logic        out_placed,
  output logic [14:0] out_pos_x,
  output logic [14:0] out_pos_y,
  output logic        out_rotated,
  output logic [15:0] out_atlas_width_out,
  output logic [15:0] out_atlas_height_out,
  output logic        out_list_overflow
);

  cmd_t  cmd;
  stat_t stat;

  mrbp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .busy         (busy),
    .cmd          (cmd)
  );

  mrbp_datapath #(
    .MAX_FREE_RECTS (MAX_FREE_RECTS),
    .MAX_ATLAS_SIZE (MAX_ATLAS_SIZE)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_rect_width        (in_rect_width),
    .in_rect_height       (in_rect_height),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_placed           (out_placed),
    .out_pos_x            (out_pos_x),
    .out_pos_y            (out_pos_y),
    .out_rotated          (out_rotated),
    .out_atlas_width_out  (out_atlas_width_out),
    .out_atlas_height_out (out_atlas_height_out),
    .out_list_overflow    (out_list_overflow)
  );

endmodule

>>> rtl/mrbp_ctrl.sv
// sequencer for the maxrects packer: scan, grow, split, compact and prune passes
// depends on mrbp_pkg for the command and status types
module mrbp_ctrl import mrbp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  in_operation,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_RES_RST,
    S_SCAN_RD,
    S_SCAN_EX,
    S_DECIDE,
    S_GROW_RD,
    S_GROW_EX,
    S_SPLIT_RD,
    S_SPLIT_EX,
    S_SPLIT_WR,
    S_CMP1_RD,
    S_CMP1_EX,
    S_PR_I,
    S_PR_IL,
    S_PR_J,
    S_PR_JEX,
    S_CMP2_RD,
    S_CMP2_EX,
    S_RES_OK
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_INIT: begin
        cmd       = CMD_RESTART;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (!in_operation) begin
            cmd       = CMD_RESTART;
            state_nxt = S_RES_RST;
          end else begin
            cmd       = CMD_LATCH;
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_RES_RST: begin
        cmd       = CMD_RES_RST;
        state_nxt = S_IDLE;
      end
      S_SCAN_RD: begin
        state_nxt = stat.i_lt_cnt ? S_SCAN_EX : S_DECIDE;
      end
      S_SCAN_EX: begin
        cmd       = CMD_SCAN_EX;
        state_nxt = S_SCAN_RD;
      end
      S_DECIDE: begin
        if (stat.fit) begin
          cmd       = CMD_SPLIT_INIT;
          state_nxt = S_SPLIT_RD;
        end else if (stat.grow_ok) begin
          cmd       = CMD_GROW_INIT;
          state_nxt = S_GROW_RD;
        end else begin
          cmd       = CMD_RES_FAIL;
          state_nxt = S_IDLE;
        end
      end
      S_GROW_RD: begin
        if (stat.i_lt_n) begin
          state_nxt = S_GROW_EX;
        end else begin
          cmd       = CMD_GROW_END;
          state_nxt = S_SCAN_RD;
        end
      end
      S_GROW_EX: begin
        cmd       = CMD_GROW_EX;
        state_nxt = S_GROW_RD;
      end
      S_SPLIT_RD: begin
        if (stat.i_lt_n) begin
          state_nxt = S_SPLIT_EX;
        end else begin
          cmd       = CMD_CMP_INIT;
          state_nxt = S_CMP1_RD;
        end
      end
      S_SPLIT_EX: begin
        cmd       = CMD_SPLIT_EX;
        state_nxt = S_SPLIT_WR;
      end
      S_SPLIT_WR: begin
        cmd = CMD_SPLIT_WR;
        if (stat.wr_last) begin
          state_nxt = S_SPLIT_RD;
        end
      end
      S_CMP1_RD: begin
        if (stat.i_lt_cnt) begin
          state_nxt = S_CMP1_EX;
        end else begin
          cmd       = CMD_CMP_END;
          state_nxt = S_PR_I;
        end
      end
      S_CMP1_EX: begin
        cmd       = CMD_CMP_EX;
        state_nxt = S_CMP1_RD;
      end
      S_PR_I: begin
        if (!stat.i_lt_cnt) begin
          cmd       = CMD_CMP_INIT;
          state_nxt = S_CMP2_RD;
        end else if (!stat.vi) begin
          cmd = CMD_INC_I;
        end else begin
          state_nxt = S_PR_IL;
        end
      end
      S_PR_IL: begin
        cmd       = CMD_PR_ILOAD;
        state_nxt = S_PR_J;
      end
      S_PR_J: begin
        if (!stat.j_lt_cnt || !stat.vi) begin
          cmd       = CMD_INC_I;
          state_nxt = S_PR_I;
        end else if (!stat.vj) begin
          cmd = CMD_INC_J;
        end else begin
          cmd       = CMD_RD_J;
          state_nxt = S_PR_JEX;
        end
      end
      S_PR_JEX: begin
        cmd       = CMD_PR_JEX;
        state_nxt = S_PR_J;
      end
      S_CMP2_RD: begin
        if (stat.i_lt_cnt) begin
          state_nxt = S_CMP2_EX;
        end else begin
          cmd       = CMD_CMP_END;
          state_nxt = S_RES_OK;
        end
      end
      S_CMP2_EX: begin
        cmd       = CMD_CMP_EX;
        state_nxt = S_CMP2_RD;
      end
      S_RES_OK: begin
        cmd       = CMD_RES_OK;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/mrbp_datapath.sv
// datapath of the maxrects packer: free list memory, valid bits, counters,
// best-fit tracking, split and prune logic, config and result registers; uses mrbp_pkg
module mrbp_datapath import mrbp_pkg::*; #(
  parameter int MAX_FREE_RECTS = 64,
  parameter int MAX_ATLAS_SIZE = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [15:0] in_rect_width,
  input  logic [15:0] in_rect_height,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  output logic        out_placed,
  output logic [14:0] out_pos_x,
  output logic [14:0] out_pos_y,
  output logic        out_rotated,
  output logic [15:0] out_atlas_width_out,
  output logic [15:0] out_atlas_height_out,
  output logic        out_list_overflow
);

  localparam int AW = $clog2(MAX_FREE_RECTS);
  localparam int CW = $clog2(MAX_FREE_RECTS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_FREE_RECTS);
  localparam logic [16:0] MAX_SIDE = 17'(MAX_ATLAS_SIZE);
  localparam logic [16:0] HALF_SIDE = 17'(MAX_ATLAS_SIZE / 2);

  rect_t mem [MAX_FREE_RECTS];
  rect_t rd_q;

  logic                      cfg_growth_r, cfg_rot_r;
  logic [15:0]               cfg_iw_r, cfg_ih_r;
  logic [15:0]               atlas_w_r, atlas_h_r;
  logic [CW-1:0]             count_r, n_r, i_r, j_r;
  logic [MAX_FREE_RECTS-1:0] valid_r;
  logic [15:0]               req_w_r, req_h_r;
  logic                      g1_r, g2_r;
  logic [15:0]               s1_r, s2_r, x1_r, y1_r, x2_r, y2_r;
  rect_t                     place_r, pi_r;
  logic                      rot_r, ovf_r, first_r;
  rect_t                     c_r [4];
  logic [3:0]                cm_r;

  logic out_valid_r, out_placed_r, out_rotated_r, out_ovf_r;
  logic [14:0] out_x_r, out_y_r;
  logic [15:0] out_aw_r, out_ah_r;

  logic [AW-1:0] ia, ja, ca;
  assign ia = i_r[AW-1:0];
  assign ja = j_r[AW-1:0];
  assign ca = count_r[AW-1:0];

  // restart sides saturated to 1..max
  function automatic logic [15:0] clamp_side(logic [15:0] v);
    if (v == 16'd0) return 16'd1;
    if ({1'b0, v} > MAX_SIDE) return MAX_SIDE[15:0];
    return v;
  endfunction

  logic [15:0] clw, clh;
  assign clw = clamp_side(cfg_iw_r);
  assign clh = clamp_side(cfg_ih_r);

  // best-fit scoring of the entry just read
  logic        f1, f2, upd1, upd2;
  logic [15:0] a1, b1, sc1, a2, b2, sc2;
  always_comb begin
    f1   = (rd_q.w >= req_w_r) && (rd_q.h >= req_h_r);
    a1   = rd_q.w - req_w_r;
    b1   = rd_q.h - req_h_r;
    sc1  = (a1 < b1) ? a1 : b1;
    upd1 = f1 && (!g1_r || sc1 < s1_r);
    f2   = (rd_q.w >= req_h_r) && (rd_q.h >= req_w_r);
    a2   = rd_q.w - req_h_r;
    b2   = rd_q.h - req_w_r;
    sc2  = (a2 < b2) ? a2 : b2;
    upd2 = f2 && (!g2_r || sc2 < s2_r);
  end

  logic rot_sel, fit;
  assign rot_sel = cfg_rot_r && g2_r && (!g1_r || s2_r < s1_r);
  assign fit     = g1_r || (cfg_rot_r && g2_r);

  // growth along the shorter side, width on a tie
  logic grow_vert, can_grow, grow_match;
  rect_t grown, strip;
  always_comb begin
    grow_vert = atlas_w_r > atlas_h_r;
    can_grow  = grow_vert ? ({1'b0, atlas_h_r} <= HALF_SIDE)
                          : ({1'b0, atlas_w_r} <= HALF_SIDE);
    grown     = rd_q;
    if (grow_vert) begin
      grow_match = ({1'b0, rd_q.y} + {1'b0, rd_q.h}) == {1'b0, atlas_h_r};
      grown.h    = rd_q.h + atlas_h_r;
      strip      = '{x: 16'd0, y: atlas_h_r, w: atlas_w_r, h: atlas_h_r};
    end else begin
      grow_match = ({1'b0, rd_q.x} + {1'b0, rd_q.w}) == {1'b0, atlas_w_r};
      grown.w    = rd_q.w + atlas_w_r;
      strip      = '{x: atlas_w_r, y: 16'd0, w: atlas_w_r, h: atlas_h_r};
    end
  end

  // split of the entry just read against the placed rectangle
  logic [16:0] px0, px1, py0, py1, fx0, fx1, fy0, fy1;
  logic        encl, xov, yov;
  logic [3:0]  cm_nxt;
  rect_t       kid_nxt [4];
  always_comb begin
    px0 = {1'b0, place_r.x};
    py0 = {1'b0, place_r.y};
    px1 = px0 + {1'b0, place_r.w};
    py1 = py0 + {1'b0, place_r.h};
    fx0 = {1'b0, rd_q.x};
    fy0 = {1'b0, rd_q.y};
    fx1 = fx0 + {1'b0, rd_q.w};
    fy1 = fy0 + {1'b0, rd_q.h};
    encl = encloses(place_r, rd_q);
    xov  = (px0 < fx1) && (px1 > fx0);
    yov  = (py0 < fy1) && (py1 > fy0);
    cm_nxt[0] = !encl && xov && (py0 > fy0) && (py0 < fy1);
    cm_nxt[1] = !encl && xov && (py1 > fy0) && (py1 < fy1);
    cm_nxt[2] = !encl && yov && (px0 > fx0) && (px0 < fx1);
    cm_nxt[3] = !encl && yov && (px1 > fx0) && (px1 < fx1);
    kid_nxt[0] = '{x: rd_q.x, y: rd_q.y, w: rd_q.w, h: 16'(py0 - fy0)};
    kid_nxt[1] = '{x: py1[15:0] & 16'h0 | rd_q.x, y: py1[15:0], w: rd_q.w,
                   h: 16'(fy1 - py1)};
    kid_nxt[2] = '{x: rd_q.x, y: rd_q.y, w: 16'(px0 - fx0), h: rd_q.h};
    kid_nxt[3] = '{x: px1[15:0], y: rd_q.y, w: 16'(fx1 - px1), h: rd_q.h};
  end

  // lowest pending remainder goes out first
  logic [3:0] sel;
  rect_t      kid_sel;
  logic       full;
  always_comb begin
    sel = cm_r & (~cm_r + 4'd1);
    kid_sel = c_r[3];
    if (sel[0]) begin
      kid_sel = c_r[0];
    end else if (sel[1]) begin
      kid_sel = c_r[1];
    end else if (sel[2]) begin
      kid_sel = c_r[2];
    end
    full = (count_r >= MAXC);
  end

  logic vi, vj, enc_ij, enc_ji;
  assign vi     = valid_r[ia];
  assign vj     = valid_r[ja];
  assign enc_ij = encloses(pi_r, rd_q);
  assign enc_ji = encloses(rd_q, pi_r);

  always_comb begin
    stat.i_lt_cnt = i_r < count_r;
    stat.i_lt_n   = i_r < n_r;
    stat.j_lt_cnt = j_r < count_r;
    stat.vi       = vi;
    stat.vj       = vj;
    stat.fit      = fit;
    stat.grow_ok  = cfg_growth_r && can_grow;
    stat.wr_last  = (cm_r & (cm_r - 4'd1)) == 4'd0;
  end

  // memory port control
  logic          we;
  logic [AW-1:0] waddr, raddr;
  rect_t         wdata;
  always_comb begin
    we    = 1'b0;
    waddr = ia;
    wdata = rd_q;
    raddr = (cmd == CMD_RD_J) ? ja : ia;
    case (cmd)
      CMD_RESTART: begin
        we    = 1'b1;
        waddr = '0;
        wdata = '{x: 16'd0, y: 16'd0, w: clw, h: clh};
      end
      CMD_GROW_EX: begin
        we    = grow_match;
        wdata = grown;
      end
      CMD_GROW_END: begin
        we    = !full;
        waddr = ca;
        wdata = strip;
      end
      CMD_SPLIT_WR: begin
        we    = (cm_r != 4'd0) && (first_r || !full);
        waddr = first_r ? ia : ca;
        wdata = kid_sel;
      end
      CMD_CMP_EX: begin
        we    = vi;
        waddr = ja;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_growth_r <= 1'b1;
      cfg_rot_r    <= 1'b0;
      cfg_iw_r     <= RESET_ATLAS_SIDE;
      cfg_ih_r     <= RESET_ATLAS_SIDE;
      count_r      <= CW'(1);
      valid_r      <= '0;
      i_r          <= '0;
      j_r          <= '0;
      n_r          <= '0;
      g1_r         <= 1'b0;
      g2_r         <= 1'b0;
      cm_r         <= '0;
      first_r      <= 1'b0;
      ovf_r        <= 1'b0;
      rot_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_ALLOW_GROWTH:    cfg_growth_r <= cfg_wdata[0];
          REG_ALLOW_ROTATIONS: cfg_rot_r    <= cfg_wdata[0];
          REG_INIT_WIDTH:      cfg_iw_r     <= cfg_wdata;
          REG_INIT_HEIGHT:     cfg_ih_r     <= cfg_wdata;
          default:             cfg_growth_r <= cfg_growth_r;
        endcase
      end
      out_valid_r <= (cmd == CMD_RES_RST) || (cmd == CMD_RES_FAIL) || (cmd == CMD_RES_OK);
      case (cmd)
        CMD_RESTART: begin
          atlas_w_r  <= clw;
          atlas_h_r  <= clh;
          count_r    <= CW'(1);
          valid_r[0] <= 1'b1;
          ovf_r      <= 1'b0;
        end
        CMD_LATCH: begin
          req_w_r <= in_rect_width;
          req_h_r <= in_rect_height;
          ovf_r   <= 1'b0;
          i_r     <= '0;
          g1_r    <= 1'b0;
          g2_r    <= 1'b0;
        end
        CMD_SCAN_EX: begin
          if (upd1) begin
            g1_r <= 1'b1;
            s1_r <= sc1;
            x1_r <= rd_q.x;
            y1_r <= rd_q.y;
          end
          if (upd2) begin
            g2_r <= 1'b1;
            s2_r <= sc2;
            x2_r <= rd_q.x;
            y2_r <= rd_q.y;
          end
          i_r <= i_r + CW'(1);
        end
        CMD_GROW_INIT: begin
          i_r <= '0;
          n_r <= count_r;
        end
        CMD_GROW_EX: begin
          i_r <= i_r + CW'(1);
        end
        CMD_GROW_END: begin
          if (full) begin
            ovf_r <= 1'b1;
          end else begin
            valid_r[ca] <= 1'b1;
            count_r     <= count_r + CW'(1);
          end
          if (grow_vert) begin
            atlas_h_r <= {atlas_h_r[14:0], 1'b0};
          end else begin
            atlas_w_r <= {atlas_w_r[14:0], 1'b0};
          end
          i_r  <= '0;
          g1_r <= 1'b0;
          g2_r <= 1'b0;
        end
        CMD_SPLIT_INIT: begin
          place_r.x <= rot_sel ? x2_r : x1_r;
          place_r.y <= rot_sel ? y2_r : y1_r;
          place_r.w <= rot_sel ? req_h_r : req_w_r;
          place_r.h <= rot_sel ? req_w_r : req_h_r;
          rot_r     <= rot_sel;
          i_r       <= '0;
          n_r       <= count_r;
        end
        CMD_SPLIT_EX: begin
          if (encl) begin
            valid_r[ia] <= 1'b0;
          end
          cm_r    <= cm_nxt;
          c_r     <= kid_nxt;
          first_r <= 1'b1;
        end
        CMD_SPLIT_WR: begin
          if (cm_r != 4'd0) begin
            cm_r    <= cm_r & ~sel;
            first_r <= 1'b0;
            if (first_r) begin
              valid_r[ia] <= 1'b1;
            end else if (full) begin
              ovf_r <= 1'b1;
            end else begin
              valid_r[ca] <= 1'b1;
              count_r     <= count_r + CW'(1);
            end
          end
          if (stat.wr_last) begin
            i_r <= i_r + CW'(1);
          end
        end
        CMD_CMP_INIT: begin
          i_r <= '0;
          j_r <= '0;
        end
        CMD_CMP_EX: begin
          if (vi) begin
            valid_r[ja] <= 1'b1;
            j_r         <= j_r + CW'(1);
          end
          i_r <= i_r + CW'(1);
        end
        CMD_CMP_END: begin
          count_r <= j_r;
          i_r     <= '0;
        end
        CMD_INC_I: begin
          i_r <= i_r + CW'(1);
        end
        CMD_INC_J: begin
          j_r <= j_r + CW'(1);
        end
        CMD_PR_ILOAD: begin
          pi_r <= rd_q;
          j_r  <= i_r + CW'(1);
        end
        CMD_PR_JEX: begin
          if (enc_ij) begin
            valid_r[ja] <= 1'b0;
          end else if (enc_ji) begin
            valid_r[ia] <= 1'b0;
          end
          j_r <= j_r + CW'(1);
        end
        default: begin
          rot_r <= rot_r;
        end
      endcase
    end
  end

  // result registers, payload only
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_RES_OK: begin
        out_placed_r  <= 1'b1;
        out_x_r       <= place_r.x[14:0];
        out_y_r       <= place_r.y[14:0];
        out_rotated_r <= rot_r;
        out_aw_r      <= atlas_w_r;
        out_ah_r      <= atlas_h_r;
        out_ovf_r     <= ovf_r;
      end
      CMD_RES_FAIL, CMD_RES_RST: begin
        out_placed_r  <= 1'b0;
        out_x_r       <= '0;
        out_y_r       <= '0;
        out_rotated_r <= 1'b0;
        out_aw_r      <= atlas_w_r;
        out_ah_r      <= atlas_h_r;
        out_ovf_r     <= ovf_r;
      end
      default: begin
        out_placed_r <= out_placed_r;
      end
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_placed           = out_placed_r;
  assign out_pos_x            = out_x_r;
  assign out_pos_y            = out_y_r;
  assign out_rotated          = out_rotated_r;
  assign out_atlas_width_out  = out_aw_r;
  assign out_atlas_height_out = out_ah_r;
  assign out_list_overflow    = out_ovf_r;

endmodule

>>> tb/sv/max_rects_bssf_packer_checker.sv
`timescale 1ns / 1ps
// placement checker for the maxrects packer: tracks config writes, predicts every
// accepted item and compares the strobed result; depends on mrbp_pkg only
module max_rects_bssf_packer_checker import mrbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_operation,
  input  logic [15:0] in_rect_width,
  input  logic [15:0] in_rect_height,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        out_valid,
  input  logic        out_placed,
  input  logic [14:0] out_pos_x,
  input  logic [14:0] out_pos_y,
  input  logic        out_rotated,
  input  logic [15:0] out_atlas_width_out,
  input  logic [15:0] out_atlas_height_out,
  input  logic        out_list_overflow,
  output int          pending,
  output int          fail_count
);

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned ATLAS_MAX  = 32768;

  typedef struct {
    int unsigned x, y, w, h;
    bit          live;
  } span_t;

  typedef struct packed {
    logic        placed;
    logic [14:0] pos_x;
    logic [14:0] pos_y;
    logic        rotated;
    logic [15:0] atlas_w;
    logic [15:0] atlas_h;
    logic        overflow;
  } placement_t;

  span_t       free_list [LIST_DEPTH];
  int unsigned free_cnt, atlas_w, atlas_h;
  bit          growth_en, rotation_en, dropped;
  bit [15:0]   init_w, init_h;
  placement_t  placements_due [$];

  function automatic int unsigned clamp_side(int unsigned v);
    if (v < 1) return 1;
    if (v > ATLAS_MAX) return ATLAS_MAX;
    return v;
  endfunction

  function automatic bit covers(span_t a, span_t b);
    return a.x <= b.x && a.y <= b.y && a.x + a.w >= b.x + b.w && a.y + a.h >= b.y + b.h;
  endfunction

  task automatic reload_atlas();
    atlas_w = clamp_side(32'(init_w));
    atlas_h = clamp_side(32'(init_h));
    free_list[0] = '{0, 0, atlas_w, atlas_h, 1'b1};
    free_cnt = 1;
  endtask

  task automatic add_free(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
    if (free_cnt >= LIST_DEPTH) begin
      dropped = 1'b1;
    end else begin
      free_list[free_cnt] = '{x, y, w, h, 1'b1};
      free_cnt++;
    end
  endtask

  task automatic squeeze();
    int unsigned k;
    k = 0;
    for (int unsigned i = 0; i < free_cnt; i++)
      if (free_list[i].live) begin
        free_list[k] = free_list[i];
        k++;
      end
    free_cnt = k;
  endtask

  // doubles along the shorter side, width on a tie
  task automatic double_atlas(output bit ok);
    int unsigned n;
    n = free_cnt;
    ok = 1'b1;
    if (atlas_w > atlas_h) begin
      if (atlas_h > ATLAS_MAX / 2) begin
        ok = 1'b0;
      end else begin
        for (int unsigned i = 0; i < n; i++)
          if (free_list[i].y + free_list[i].h == atlas_h) free_list[i].h += atlas_h;
        add_free(0, atlas_h, atlas_w, atlas_h);
        atlas_h *= 2;
      end
    end else begin
      if (atlas_w > ATLAS_MAX / 2) begin
        ok = 1'b0;
      end else begin
        for (int unsigned i = 0; i < n; i++)
          if (free_list[i].x + free_list[i].w == atlas_w) free_list[i].w += atlas_w;
        add_free(atlas_w, 0, atlas_w, atlas_h);
        atlas_w *= 2;
      end
    end
  endtask

  task automatic short_side_fit(int unsigned w, int unsigned h, output bit got,
                                output int unsigned idx, output int unsigned score);
    int unsigned a, b, s;
    got = 1'b0;
    idx = 0;
    score = 0;
    for (int unsigned i = 0; i < free_cnt; i++)
      if (free_list[i].w >= w && free_list[i].h >= h) begin
        a = free_list[i].w - w;
        b = free_list[i].h - h;
        s = (a < b) ? a : b;
        if (!got || s < score) begin
          got = 1'b1;
          idx = i;
          score = s;
        end
      end
  endtask

  task automatic carve(span_t p);
    int unsigned n, k, px1, py1, fx1, fy1;
    span_t f;
    span_t c [4];
    n = free_cnt;
    px1 = p.x + p.w;
    py1 = p.y + p.h;
    for (int unsigned i = 0; i < n; i++) begin
      f = free_list[i];
      fx1 = f.x + f.w;
      fy1 = f.y + f.h;
      if (covers(p, f)) begin
        free_list[i].live = 1'b0;
        continue;
      end
      k = 0;
      if (p.x < fx1 && px1 > f.x) begin
        if (p.y > f.y && p.y < fy1) begin c[k] = '{f.x, f.y, f.w, p.y - f.y, 1'b1}; k++; end
        if (py1 > f.y && py1 < fy1) begin c[k] = '{f.x, py1, f.w, fy1 - py1, 1'b1}; k++; end
      end
      if (p.y < fy1 && py1 > f.y) begin
        if (p.x > f.x && p.x < fx1) begin c[k] = '{f.x, f.y, p.x - f.x, f.h, 1'b1}; k++; end
        if (px1 > f.x && px1 < fx1) begin c[k] = '{px1, f.y, fx1 - px1, f.h, 1'b1}; k++; end
      end
      // first remainder stays in place, the rest go to the tail
      for (int unsigned j = 0; j < k; j++)
        if (j == 0) free_list[i] = c[0];
        else add_free(c[j].x, c[j].y, c[j].w, c[j].h);
    end
    squeeze();
  endtask

  task automatic drop_contained();
    for (int unsigned i = 0; i < free_cnt; i++) begin
      if (!free_list[i].live) continue;
      for (int unsigned j = i + 1; j < free_cnt; j++) begin
        if (!free_list[j].live) continue;
        if (covers(free_list[i], free_list[j])) begin
          free_list[j].live = 1'b0;
        end else if (covers(free_list[j], free_list[i])) begin
          free_list[i].live = 1'b0;
          break;
        end
      end
    end
    squeeze();
  endtask

  task automatic place_item(bit op, int unsigned w, int unsigned h, output placement_t r);
    bit placed, rot, g1, g2, ok;
    int unsigned i1, s1, i2, s2, px, py;
    span_t p;
    placed = 1'b0;
    rot = 1'b0;
    px = 0;
    py = 0;
    dropped = 1'b0;
    if (!op) begin
      reload_atlas();
    end else begin
      forever begin
        short_side_fit(w, h, g1, i1, s1);
        g2 = 1'b0;
        if (rotation_en) short_side_fit(h, w, g2, i2, s2);
        if (g2 && (!g1 || s2 < s1)) begin
          rot = 1'b1;
          i1 = i2;
          g1 = 1'b1;
        end
        if (g1) begin
          p = '{free_list[i1].x, free_list[i1].y, rot ? h : w, rot ? w : h, 1'b1};
          px = p.x;
          py = p.y;
          carve(p);
          drop_contained();
          placed = 1'b1;
          break;
        end
        ok = 1'b0;
        if (growth_en) double_atlas(ok);
        if (!ok) begin
          rot = 1'b0;
          break;
        end
      end
    end
    r.placed   = placed;
    r.pos_x    = px[14:0];
    r.pos_y    = py[14:0];
    r.rotated  = rot;
    r.atlas_w  = atlas_w[15:0];
    r.atlas_h  = atlas_h[15:0];
    r.overflow = dropped;
  endtask

  always @(posedge clk) begin
    placement_t want, got;
    if (!rst_n) begin
      growth_en   = 1'b1;
      rotation_en = 1'b0;
      init_w      = RESET_ATLAS_SIDE;
      init_h      = RESET_ATLAS_SIDE;
      reload_atlas();
      placements_due.delete();
      fail_count  = 0;
      pending     = 0;
    end else begin
      // result of the previous item is checked before a new item is predicted
      if (out_valid) begin
        got = '{out_placed, out_pos_x, out_pos_y, out_rotated,
                out_atlas_width_out, out_atlas_height_out, out_list_overflow};
        if (placements_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", got);
        end else begin
          want = placements_due.pop_front();
          if (want != got) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_ALLOW_GROWTH:    growth_en = cfg_wdata[0];
          REG_ALLOW_ROTATIONS: rotation_en = cfg_wdata[0];
          REG_INIT_WIDTH:      init_w = cfg_wdata;
          REG_INIT_HEIGHT:     init_h = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        place_item(in_operation, 32'(in_rect_width), 32'(in_rect_height), want);
        placements_due = {placements_due, want};
      end
      pending = placements_due.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// top of the maxrects packer bench: clock, reset, config phases and item stimulus;
// depends on mrbp_pkg, max_rects_bssf_packer and max_rects_bssf_packer_checker
module testbench;
  import mrbp_pkg::*;

  localparam longint CYCLE_LIMIT = 80_000_000;

  logic        clk, rst_n, start, busy;
  logic        in_operation;
  logic [15:0] in_rect_width, in_rect_height;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  logic        out_valid, out_placed, out_rotated, out_list_overflow;
  logic [14:0] out_pos_x, out_pos_y;
  logic [15:0] out_atlas_width_out, out_atlas_height_out;
  int          pending, fail_count;
  longint      cycles = 0;
  int          item_no;

  max_rects_bssf_packer i_dut (.*);
  max_rects_bssf_packer_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [15:0] pick_side();
    int sel;
    sel = int'($urandom_range(0, 99));
    if (sel < 70) return 16'($urandom_range(0, 64));
    if (sel < 85) return 16'($urandom_range(0, 512));
    if (sel < 95) return 16'($urandom_range(0, 32768));
    case ($urandom_range(0, 2))
      0: return 16'd0;
      1: return 16'd32767;
      default: return 16'd32768;
    endcase
  endfunction

  // start is dropped first so a held item is not taken again
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // drive one item, hold until accepted, then maybe leave a gap
  task automatic send(logic op, logic [15:0] w, logic [15:0] h, bit may_idle);
    start          <= 1'b1;
    in_operation   <= op;
    in_rect_width  <= w;
    in_rect_height <= h;
    do @(negedge clk); while (busy);
    @(posedge clk);
    item_no++;
    if (may_idle && $urandom_range(0, 99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic run_phase(logic [15:0] grow, logic [15:0] rot, logic [15:0] iw,
                           logic [15:0] ih, int count);
    bit calm;
    wait_idle();
    start <= 1'b0;
    write_reg(REG_ALLOW_GROWTH, grow);
    write_reg(REG_ALLOW_ROTATIONS, rot);
    write_reg(REG_INIT_WIDTH, iw);
    write_reg(REG_INIT_HEIGHT, ih);
    send(1'b0, 16'($urandom), 16'($urandom), 1'b1);
    for (int k = 0; k < count; k++) begin
      calm = (item_no >= 500 && item_no < 700);
      if ($urandom_range(0, 99) < 3) send(1'b0, pick_side(), pick_side(), !calm);
      else send(1'b1, pick_side(), pick_side(), !calm);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = 1'b0;
    in_rect_width  = '0;
    in_rect_height = '0;
    cfg_we         = 1'b0;
    cfg_addr       = REG_ALLOW_GROWTH;
    cfg_wdata      = '0;
    item_no        = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // directed items on reset settings: zero size, extremes, growth to the maximum
    send(1'b1, 16'd0, 16'd0, 1'b0);
    send(1'b1, 16'd512, 16'd512, 1'b0);
    send(1'b1, 16'd1, 16'd1, 1'b0);
    send(1'b1, 16'd32768, 16'd32768, 1'b0);
    send(1'b1, 16'd32768, 16'd1, 1'b0);
    send(1'b0, 16'hffff, 16'hffff, 1'b0);
    send(1'b1, 16'd700, 16'd10, 1'b0);
    send(1'b1, 16'd32767, 16'd32767, 1'b0);
    for (int k = 0; k < 12; k++) send(1'b1, 16'(1 + k), 16'd3, 1'b0);
    // no growth, rotations: fit only when turned, and plain failure
    wait_idle();
    write_reg(REG_ALLOW_GROWTH, 16'd0);
    write_reg(REG_ALLOW_ROTATIONS, 16'd1);
    write_reg(REG_INIT_WIDTH, 16'd100);
    write_reg(REG_INIT_HEIGHT, 16'd20);
    send(1'b0, 16'd0, 16'd0, 1'b0);
    send(1'b1, 16'd10, 16'd60, 1'b0);
    send(1'b1, 16'd200, 16'd5, 1'b0);
    send(1'b1, 16'd5, 16'd5, 1'b0);

    // hold off until everything queued has come back
    wait_idle();
    start <= 1'b0;
    repeat (5) @(posedge clk);

    run_phase(16'd1, 16'd0, 16'd512, 16'd512, 200);
    run_phase(16'd1, 16'd1, 16'd0, 16'd0, 160);
    run_phase(16'd0, 16'd1, 16'd32768, 16'd32768, 160);
    run_phase(16'd1, 16'd1, 16'hffff, 16'd1, 160);
    run_phase(16'd0, 16'd0, 16'd64, 16'd48, 150);
    run_phase(16'hfffe, 16'hffff, 16'd1, 16'd32768, 150);
    for (int ph = 0; ph < 2; ph++)
      run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(1, 2048)),
                16'($urandom_range(1, 2048)), 150);

    start <= 1'b0;
    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> max_rects_bssf_packer.f
rtl/mrbp_pkg.sv
rtl/mrbp_ctrl.sv
rtl/mrbp_datapath.sv
rtl/max_rects_bssf_packer.sv
tb/sv/max_rects_bssf_packer_checker.sv
tb/sv/testbench.sv
